// File: rtl/parking_gate_occupancy_controller_defines.svh
// Assertion macros used by the parking gate controller top level.
`ifndef PARKING_GATE_OCCUPANCY_CONTROLLER_DEFINES_SVH
`define PARKING_GATE_OCCUPANCY_CONTROLLER_DEFINES_SVH

// Concurrent check on clk, masked while rst is high.
`define PGOC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on clk that also holds through reset.
`define PGOC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pgoc_pkg.sv
// Types and constants shared by the parking gate controller modules.
`timescale 1ns / 1ps
`default_nettype none

package pgoc_pkg;

  typedef enum logic [1:0] {
    GATE_CLOSED   = 2'd0,
    GATE_DETECTED = 2'd1,
    GATE_OPEN     = 2'd2,
    GATE_PASSING  = 2'd3
  } gate_state_t;

  typedef enum logic [1:0] {
    STATUS_AVAILABLE = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2
  } lot_status_t;

  localparam logic [7:0] CAPACITY_RESET = 8'd15;

  // Control from the top level into one gate.
  typedef struct packed {
    logic step;          // a tick is transferred this cycle
    logic force_closed;  // lot status holds this gate shut
  } gate_ctrl_t;

  // Flags of a gate's state after the tick.
  typedef struct packed {
    logic open;
    logic passing;
  } gate_flags_t;

endpackage

`default_nettype wire

// File: rtl/parking_gate_occupancy_controller.sv
// Top level of the parking gate occupancy controller.
`timescale 1ns / 1ps
`default_nettype none
`include "parking_gate_occupancy_controller_defines.svh"

// One tick of sampled entry and exit sensor levels is transferred on the
// input channel whenever in_valid is high and in_stall is low, one tick per
// clock at full rate. The tick's work is a single combinational pass through
// the two gate state machines and the saturating car counter, and its result
// lands in the output register on the edge that takes the tick, so it shows
// in the next cycle. The input stalls only while that register holds a result
// that the output side is stalling. Lot status is judged from the count held
// before the tick: empty (count zero) wins over full (count at or above
// capacity). A full lot forces the entry gate closed and an empty lot forces
// the exit gate closed. The count saturates at the smaller of capacity and
// the largest COUNT_BITS value; car_count carries its low eight bits.
// count_changed is set on the first tick after reset and whenever the count
// moves. capacity is written through capacity_we / capacity_wdata, resets to
// 15, and the user must write it only while the block is idle; no check here.

module parking_gate_occupancy_controller #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       capacity_we,
  input  wire logic [7:0] capacity_wdata,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       entry_weight,
  input  wire logic       entry_card,
  input  wire logic       exit_weight,
  input  wire logic       exit_card,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            entry_gate_open,
  output logic            exit_gate_open,
  output logic [1:0]      lot_status,
  output logic            available_lamp,
  output logic            full_lamp,
  output logic [7:0]      car_count,
  output logic            count_changed
);

  logic [7:0]             capacity;
  logic                   in_xfer;
  pgoc_pkg::lot_status_t  status;
  pgoc_pkg::gate_ctrl_t   entry_ctrl;
  pgoc_pkg::gate_ctrl_t   exit_ctrl;
  pgoc_pkg::gate_flags_t  entry_flags;
  pgoc_pkg::gate_flags_t  exit_flags;
  logic [COUNT_BITS-1:0]  count_next;
  logic                   changed;

  // Output register frees up when its result is transferred out.
  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= pgoc_pkg::CAPACITY_RESET;
    end else if (capacity_we) begin
      capacity <= capacity_wdata;
    end
  end

  assign entry_ctrl.step         = in_xfer;
  assign entry_ctrl.force_closed = (status == pgoc_pkg::STATUS_FULL);
  assign exit_ctrl.step          = in_xfer;
  assign exit_ctrl.force_closed  = (status == pgoc_pkg::STATUS_EMPTY);

  pgoc_gate u_entry_gate (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (entry_ctrl),
    .weight (entry_weight),
    .card   (entry_card),
    .flags  (entry_flags)
  );

  pgoc_gate u_exit_gate (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (exit_ctrl),
    .weight (exit_weight),
    .card   (exit_card),
    .flags  (exit_flags)
  );

  pgoc_occupancy #(
    .COUNT_BITS (COUNT_BITS)
  ) u_occupancy (
    .clk           (clk),
    .rst           (rst),
    .step          (in_xfer),
    .capacity      (capacity),
    .entry_passing (entry_flags.passing),
    .exit_passing  (exit_flags.passing),
    .status        (status),
    .count_next    (count_next),
    .changed       (changed)
  );

  // Result register: valid is control, payload loads with each tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      entry_gate_open <= entry_flags.open;
      exit_gate_open  <= exit_flags.open;
      lot_status      <= status;
      available_lamp  <= (status != pgoc_pkg::STATUS_FULL);
      full_lamp       <= (status == pgoc_pkg::STATUS_FULL);
      car_count       <= 8'(count_next);
      count_changed   <= changed;
    end
  end

  `PGOC_ASSERT(a_full_entry_shut, out_valid && (lot_status == pgoc_pkg::STATUS_FULL) |-> !entry_gate_open, "entry gate open while lot full")
  `PGOC_ASSERT(a_empty_exit_shut, out_valid && (lot_status == pgoc_pkg::STATUS_EMPTY) |-> !exit_gate_open, "exit gate open while lot empty")
  `PGOC_ASSERT(a_result_follows, in_valid && !in_stall |=> out_valid, "transfer in left no result")
  `PGOC_ASSERT_ALWAYS(a_hold_blocks_input, out_valid && out_stall |-> in_stall, "input taken while result held")

endmodule

`default_nettype wire

// File: rtl/pgoc_gate.sv
// Four-state barrier controller for one gate.
`timescale 1ns / 1ps
`default_nettype none

module pgoc_gate (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pgoc_pkg::gate_ctrl_t ctrl,
  input  wire logic               weight,
  input  wire logic               card,
  output pgoc_pkg::gate_flags_t   flags
);

  pgoc_pkg::gate_state_t state;
  pgoc_pkg::gate_state_t state_next;

  always_comb begin
    state_next = pgoc_pkg::GATE_CLOSED;
    if (!ctrl.force_closed) begin
      case (state)
        pgoc_pkg::GATE_CLOSED: begin
          state_next = weight ? pgoc_pkg::GATE_DETECTED : pgoc_pkg::GATE_CLOSED;
        end
        pgoc_pkg::GATE_DETECTED: begin
          if (!weight) state_next = pgoc_pkg::GATE_CLOSED;
          else if (card) state_next = pgoc_pkg::GATE_OPEN;
          else state_next = pgoc_pkg::GATE_DETECTED;
        end
        pgoc_pkg::GATE_OPEN: begin
          state_next = weight ? pgoc_pkg::GATE_OPEN : pgoc_pkg::GATE_PASSING;
        end
        default: begin
          state_next = pgoc_pkg::GATE_CLOSED;
        end
      endcase
    end
  end

  // flags describe the state the tick leaves behind
  always_comb begin
    flags.open    = (state_next == pgoc_pkg::GATE_OPEN);
    flags.passing = (state_next == pgoc_pkg::GATE_PASSING);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgoc_pkg::GATE_CLOSED;
    end else if (ctrl.step) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pgoc_occupancy.sv
// Car counter with lot status decode and change detection.
`timescale 1ns / 1ps
`default_nettype none

module pgoc_occupancy #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    step,
  input  wire logic [7:0]              capacity,
  input  wire logic                    entry_passing,
  input  wire logic                    exit_passing,
  output pgoc_pkg::lot_status_t        status,
  output logic [COUNT_BITS-1:0]        count_next,
  output logic                         changed
);

  localparam int CMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [CMP_BITS-1:0] COUNT_MAX = CMP_BITS'({COUNT_BITS{1'b1}});

  logic [COUNT_BITS-1:0] count;
  logic                  reported_valid;
  logic [CMP_BITS-1:0]   count_ext;
  logic [CMP_BITS-1:0]   cap_ext;
  logic [CMP_BITS-1:0]   limit;
  logic [COUNT_BITS-1:0] count_mid;

  assign count_ext = CMP_BITS'(count);
  assign cap_ext   = CMP_BITS'(capacity);
  assign limit     = (cap_ext < COUNT_MAX) ? cap_ext : COUNT_MAX;

  // empty wins over full
  always_comb begin
    if (count == '0) status = pgoc_pkg::STATUS_EMPTY;
    else if (count_ext >= cap_ext) status = pgoc_pkg::STATUS_FULL;
    else status = pgoc_pkg::STATUS_AVAILABLE;
  end

  // entry first, then exit; both saturate
  always_comb begin
    count_mid = count;
    if (entry_passing && (count_ext < limit)) count_mid = count + 1'b1;
    count_next = count_mid;
    if (exit_passing && (count_mid != '0)) count_next = count_mid - 1'b1;
  end

  // the last reported value is always the held count
  assign changed = !reported_valid || (count_next != count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      reported_valid <= 1'b0;
    end else if (step) begin
      count          <= count_next;
      reported_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire
